/* src/cse_pkg.sv */
// Shared widths, limits and codes for the Chebyshev series evaluator.
package cse_pkg;

   // Field widths fixed by the item formats.
   localparam int unsigned COEF_W   = 32;  // coefficient, signed Q16.16
   localparam int unsigned X_W      = 32;  // evaluation point, signed Q2.30
   localparam int unsigned IDX_IN_W = 4;   // coefficient index field
   localparam int unsigned TERMS_W  = 5;   // terms_in_use register
   localparam int unsigned RESULT_W = 32;  // series value, signed Q16.16

   // Recurrence state, signed Q32.16.
   localparam int unsigned ACC_W = 48;

   // Wide enough to hold any table depth up to 256 and any term count.
   localparam int unsigned CNT_W = 9;

   localparam int unsigned DEFAULT_MAX_TERMS = 16;
   localparam logic [TERMS_W-1:0] TERMS_RESET = 5'd16;

   // Item kinds carried on tuser of the request channel.
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_EVAL  = 1'b1;

endpackage

/* src/chebyshev_series_evaluator_top.sv */
// Chebyshev series evaluator: Clenshaw recurrence on one shared multiplier.
//
// Usage. Items arrive on the req_ stream. req_tuser selects the kind of item:
// a coefficient write stores req_tdata's coefficient at its table index and
// gives no result; an evaluation computes the series at the given point and
// gives exactly one result item on the rsp_ stream, with the saturation flag
// on rsp_tuser. The user must write terms_in_use on the csr_ port only while
// the block is idle; the block itself does not enforce this.
// Timing. A write item is taken whenever the block is idle and leaves it
// idle. An evaluation with n terms in use runs n steps (low partial product,
// high partial product, 81-bit accumulate with rounding, recurrence update
// and clip); its result is registered at the end of the last step, and no
// new item is taken before then. The single 32 x 25 multiplier is used twice
// per step.
//
// Reset clears the sequencer and the output valid and sets terms_in_use to
// 16. The coefficient table is not cleared: write every coefficient in use.
// A waiting result does not block new items, but an evaluation that finishes
// behind it holds in its last step, with req_tready low, until it is taken.
module chebyshev_series_evaluator_top
   import cse_pkg::*;
#(
   parameter int unsigned MAX_TERMS = DEFAULT_MAX_TERMS
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 csr_wr_en,
   input  logic [TERMS_W-1:0]   csr_wr_data,   // terms_in_use

   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [71:0]          req_tdata,     // coef_index[3:0], coef_value[35:4],
                                               // x_value[67:36], zero[71:68]
   input  logic                 req_tuser,     // mode

   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RESULT_W-1:0]  rsp_tdata,     // series_value[31:0]
   output logic                 rsp_tuser      // saturated
);

   localparam int unsigned IDX_W  = $clog2(MAX_TERMS);
   localparam int unsigned MUL_W  = 57;   // 32-bit x 25-bit signed product
   localparam int unsigned SUM_W  = 81;   // full x*d product plus rounding
   localparam int unsigned T_W    = 54;   // shifted product plus two addends

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL_LO,
      S_MUL_HI,
      S_ACCUM,
      S_UPDATE
   } state_type;

   // Request fields.
   logic [IDX_IN_W-1:0]      req_coef_index;
   logic signed [COEF_W-1:0] req_coef_value;
   logic signed [X_W-1:0]    req_x_value;
   logic                     req_accept;

   assign req_coef_index = req_tdata[3:0];
   assign req_coef_value = req_tdata[35:4];
   assign req_x_value    = req_tdata[67:36];
   assign req_accept     = req_tvalid && req_tready;

   // Registers.
   state_type                state_ff;
   logic [TERMS_W-1:0]       terms_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic signed [X_W-1:0]    x_ff;
   logic signed [ACC_W-1:0]  d_ff;
   logic signed [ACC_W-1:0]  dd_ff;
   logic signed [MUL_W-1:0]  lo_ff;
   logic signed [MUL_W-1:0]  hi_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [COEF_W-1:0] coef_rd_ff;
   logic                     sat_ff;
   logic                     rsp_valid_ff;
   logic [RESULT_W-1:0]      rsp_data_ff;
   logic                     rsp_sat_ff;

   logic signed [COEF_W-1:0] coef_mem [MAX_TERMS];

   // Coefficient write decode.
   logic [CNT_W-1:0] wr_idx_wide;
   logic             wr_en;

   assign wr_idx_wide = CNT_W'(req_coef_index);
   assign wr_en = req_accept && (req_tuser == MODE_WRITE)
                  && (wr_idx_wide < CNT_W'(MAX_TERMS));

   // Number of terms, clamped to 1 .. MAX_TERMS; the walk starts at n-1.
   logic [CNT_W-1:0] n_req;
   logic [CNT_W-1:0] n_use;
   logic [CNT_W-1:0] start_in;

   assign n_req = CNT_W'(terms_ff);
   always_comb begin
      if (n_req > CNT_W'(MAX_TERMS)) begin
         n_use = CNT_W'(MAX_TERMS);
      end else if (n_req == '0) begin
         n_use = CNT_W'(1);
      end else begin
         n_use = n_req;
      end
      start_in = n_use - CNT_W'(1);
   end

   // Shared multiplier: low 24 bits of d (as positive) or the high 24 bits.
   logic              last_step;
   logic signed [24:0] mul_b;
   logic signed [MUL_W-1:0] mul_in;

   assign last_step = (idx_ff == '0);
   assign mul_b  = (state_ff == S_MUL_LO) ? $signed({1'b0, d_ff[23:0]})
                                          : $signed({d_ff[47], d_ff[47:24]});
   assign mul_in = MUL_W'(x_ff) * MUL_W'(mul_b);

   // Full product with round-half-up constant for the final shift.
   logic signed [SUM_W-1:0] rnd;
   logic signed [SUM_W-1:0] sum_in;

   assign rnd    = last_step ? (SUM_W'(1) <<< 29) : (SUM_W'(1) <<< 28);
   assign sum_in = $signed({hi_ff, 24'b0}) + $signed({{24{lo_ff[MUL_W-1]}}, lo_ff}) + rnd;

   // Recurrence update: 2x*d rounded for inner steps, x*d rounded at the end.
   logic signed [SUM_W-1:0] shifted;
   logic signed [T_W-1:0]   t_in;
   logic                    d_fits;
   logic                    y_fits;
   logic signed [ACC_W-1:0] d_in;
   logic [RESULT_W-1:0]     y_in;

   assign shifted = last_step ? (sum_ff >>> 30) : (sum_ff >>> 29);
   assign t_in = $signed(shifted[T_W-1:0])
                 - $signed({{(T_W-ACC_W){dd_ff[ACC_W-1]}}, dd_ff})
                 + $signed({{(T_W-COEF_W){coef_rd_ff[COEF_W-1]}}, coef_rd_ff});

   // A value fits when all bits above the target sign bit copy it.
   assign d_fits = (t_in[T_W-1:ACC_W-1] == '0) || (t_in[T_W-1:ACC_W-1] == '1);
   assign y_fits = (t_in[T_W-1:RESULT_W-1] == '0) || (t_in[T_W-1:RESULT_W-1] == '1);

   always_comb begin
      if (d_fits) begin
         d_in = t_in[ACC_W-1:0];
      end else if (t_in[T_W-1]) begin
         d_in = {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
         d_in = {1'b0, {(ACC_W-1){1'b1}}};
      end
      if (y_fits) begin
         y_in = t_in[RESULT_W-1:0];
      end else if (t_in[T_W-1]) begin
         y_in = {1'b1, {(RESULT_W-1){1'b0}}};
      end else begin
         y_in = {1'b0, {(RESULT_W-1){1'b1}}};
      end
   end

   logic out_free;
   logic result_done;
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign result_done = (state_ff == S_UPDATE) && last_step && out_free;

   // Coefficient table: written by write items, read at the start of each step.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         coef_mem[wr_idx_wide[IDX_W-1:0]] <= req_coef_value;
      end
      if (state_ff == S_MUL_LO) begin
         coef_rd_ff <= coef_mem[idx_ff];
      end
   end

   // Sequencer and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         terms_ff     <= TERMS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            terms_ff <= csr_wr_data;
         end
         if (result_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_accept && (req_tuser == MODE_EVAL)) begin
                  x_ff     <= req_x_value;
                  d_ff     <= '0;
                  dd_ff    <= '0;
                  sat_ff   <= 1'b0;
                  idx_ff   <= start_in[IDX_W-1:0];
                  state_ff <= S_MUL_LO;
               end
            end
            S_MUL_LO: begin
               lo_ff    <= mul_in;
               state_ff <= S_MUL_HI;
            end
            S_MUL_HI: begin
               hi_ff    <= mul_in;
               state_ff <= S_ACCUM;
            end
            S_ACCUM: begin
               sum_ff   <= sum_in;
               state_ff <= S_UPDATE;
            end
            S_UPDATE: begin
               if (!last_step) begin
                  dd_ff    <= d_ff;
                  d_ff     <= d_in;
                  sat_ff   <= sat_ff || !d_fits;
                  idx_ff   <= idx_ff - IDX_W'(1);
                  state_ff <= S_MUL_LO;
               end else if (out_free) begin
                  rsp_data_ff  <= y_in;
                  rsp_sat_ff   <= sat_ff || !y_fits;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

endmodule

/* src/cse_checker.sv */
// Port-level checks for the Chebyshev series evaluator, bound to its top level.
module cse_checker
   import cse_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                req_tuser,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RESULT_W-1:0] rsp_tdata,
   input logic                rsp_tuser
);

   // Reset empties the output register.
   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A waiting result keeps its value and flag.
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // An accepted evaluation occupies the block in the next cycle.
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == MODE_EVAL) |=> !req_tready)
      else $error("ready right after an evaluation item");

   // A new result comes only out of a running evaluation.
   a_result_from_eval: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared while idle");

endmodule

bind chebyshev_series_evaluator_top cse_checker u_cse_checker (.*);

/* dv/tb_chebyshev_series_evaluator_top.sv */
// Self-checking testbench for the Chebyshev series evaluator top level.
module tb_chebyshev_series_evaluator_top;
   import cse_pkg::*;

   // The block is built with its default table depth.
   localparam int unsigned TABLE_DEPTH = DEFAULT_MAX_TERMS;

   // Writes give no result, so the testbench lets SETTLE_CYCLES pass after the
   // last result before it touches the term count.
   localparam int unsigned SETTLE_CYCLES = 80;

   // Length of the long receiver hold-off that fills the block up.
   localparam int unsigned HOLD_CYCLES = 400;

   // Cycles without any accepted item on either channel before the run is
   // declared hung. The longest correct quiet stretch is the hold-off above.
   localparam int unsigned WATCHDOG_LIMIT = 4000;

   localparam int unsigned RANDOM_PHASES   = 9;
   localparam int unsigned ITEMS_PER_PHASE = 95;
   localparam int unsigned BURST_ITEMS     = 24;

   // Evaluation points of interest in Q2.30.
   localparam logic [X_W-1:0] X_ZERO      = 32'h0000_0000;
   localparam logic [X_W-1:0] X_PLUS_ONE  = 32'h4000_0000;
   localparam logic [X_W-1:0] X_MINUS_ONE = 32'hC000_0000;
   localparam logic [X_W-1:0] X_HALF      = 32'h2000_0000;
   localparam logic [X_W-1:0] X_NEG_HALF  = 32'hE000_0000;
   localparam logic [X_W-1:0] WORD_MAX    = 32'h7FFF_FFFF;
   localparam logic [X_W-1:0] WORD_MIN    = 32'h8000_0000;

   // Clipping bounds for the recurrence state and the final value.
   localparam logic signed [95:0] D_HIGH = (96'sd1 <<< (ACC_W - 1)) - 96'sd1;
   localparam logic signed [95:0] D_LOW  = -(96'sd1 <<< (ACC_W - 1));
   localparam logic signed [95:0] R_HIGH = 96'sd2147483647;
   localparam logic signed [95:0] R_LOW  = -96'sd2147483648;

   typedef struct packed {
      logic [RESULT_W-1:0] value;
      logic                sat;
   } series_result_type;

   // Clock, reset and the block's inputs all start at known values.
   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                csr_wr_en   = 1'b0;
   logic [TERMS_W-1:0]  csr_wr_data = '0;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [71:0]         req_tdata   = '0;  // coef_index[3:0], coef_value[35:4],
                                           // x_value[67:36], zero[71:68]
   logic                req_tuser   = MODE_WRITE;  // mode
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [RESULT_W-1:0] rsp_tdata;             // series_value[31:0]
   logic                rsp_tuser;             // saturated

   // Mirror of the block's state: the coefficient table and the term count.
   logic signed [COEF_W-1:0] coef_mirror [TABLE_DEPTH];
   logic [TERMS_W-1:0]       terms_mirror = TERMS_RESET;

   // Results still owed by the block, oldest first.
   series_result_type pending_series [$];

   // Shared controls between the stimulus and the receiver.
   bit  idling_on     = 1'b1;
   int  hold_requests = 0;
   int  hold_served   = 0;
   int  hold_left     = 0;
   int  stall_left    = 0;

   // Run statistics.
   int          mismatch_count = 0;
   int          writes_sent    = 0;
   int          evals_sent     = 0;
   int          results_seen   = 0;
   int          sat_seen       = 0;
   int          quiet_cycles   = 0;
   logic [31:0] terms_tried    = '0;

   always #4 clock = ~clock;

   chebyshev_series_evaluator_top #(
      .MAX_TERMS (TABLE_DEPTH)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         coef_mirror[k] = '0;
      end
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Rounds x*d / 2^shift to nearest, ties toward plus infinity. The full
   // product is formed exactly in 96 bits, so the arithmetic shift is a floor.
   function automatic logic signed [95:0] scaled_product(input logic signed [X_W-1:0] x,
                                                         input logic signed [ACC_W-1:0] d,
                                                         input int unsigned shift);
      logic signed [95:0] wide_x;
      logic signed [95:0] wide_d;
      logic signed [95:0] prod;
      wide_x = x;
      wide_d = d;
      prod   = wide_x * wide_d + (96'sd1 <<< (shift - 1));
      return prod >>> shift;
   endfunction

   // Clenshaw's recurrence over the mirrored table. A shift of 29 on the
   // Q2.30 point gives the doubled term 2x*d; the closing step uses x*d.
   function automatic series_result_type clenshaw_eval(input logic signed [X_W-1:0] x);
      int                       n;
      int                       i;
      logic signed [ACC_W-1:0]  d;
      logic signed [ACC_W-1:0]  dd;
      logic signed [95:0]       t;
      series_result_type        r;
      n = int'(terms_mirror);
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      if (n < 1) n = 1;
      d     = '0;
      dd    = '0;
      r.sat = 1'b0;
      for (i = n - 1; i >= 1; i--) begin
         t  = scaled_product(x, d, 29) - dd + coef_mirror[i];
         dd = d;
         if (t > D_HIGH) begin
            d     = D_HIGH[ACC_W-1:0];
            r.sat = 1'b1;
         end else if (t < D_LOW) begin
            d     = D_LOW[ACC_W-1:0];
            r.sat = 1'b1;
         end else begin
            d = t[ACC_W-1:0];
         end
      end
      t = scaled_product(x, d, 30) - dd + coef_mirror[0];
      if (t > R_HIGH) begin
         r.value = R_HIGH[RESULT_W-1:0];
         r.sat   = 1'b1;
      end else if (t < R_LOW) begin
         r.value = R_LOW[RESULT_W-1:0];
         r.sat   = 1'b1;
      end else begin
         r.value = t[RESULT_W-1:0];
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Random value helpers
   // ------------------------------------------------------------------

   // Mostly back to back, some short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (!idling_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Coefficients: mostly modest Q16.16 values so that many evaluations
   // stay in range, plus the full range and the two extremes.
   function automatic logic [COEF_W-1:0] random_coef();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
      if (r < 4) return $urandom;
      return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
   endfunction

   // Points: mostly within [-1, 1], sometimes any word, sometimes a corner.
   function automatic logic [X_W-1:0] random_point();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 4))
            0: return X_ZERO;
            1: return X_PLUS_ONE;
            2: return X_MINUS_ONE;
            3: return WORD_MAX;
            default: return WORD_MIN;
         endcase
      end
      if (r < 3) return $urandom;
      return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
   endfunction

   // ------------------------------------------------------------------
   // Driving and checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h, expected %h", what, got, want);
      mismatch_count++;
   endtask

   // Offers one item and waits for its handshake. The valid is left high on
   // return, so a following item goes out with no bubble; a gap or the idle
   // task lowers it. The predictor runs on the accepting edge.
   task automatic send_item(input logic mode, input logic [IDX_IN_W-1:0] idx,
                            input logic [COEF_W-1:0] coef, input logic [X_W-1:0] x);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {4'b0000, x, coef, idx};
      do @(posedge clock); while (!req_tready);
      if (mode == MODE_WRITE) begin
         coef_mirror[idx] = coef;
         writes_sent++;
      end else begin
         pending_series.push_back(clenshaw_eval(x));
         evals_sent++;
      end
   endtask

   task automatic send_eval(input logic [X_W-1:0] x);
      send_item(MODE_EVAL, IDX_IN_W'($urandom_range(0, 15)), $urandom, x);
   endtask

   task automatic send_write(input logic [IDX_IN_W-1:0] idx, input logic [COEF_W-1:0] coef);
      send_item(MODE_WRITE, idx, coef, $urandom);
   endtask

   // Lowers the request valid, waits for every owed result, then lets
   // SETTLE_CYCLES more pass before it returns.
   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (pending_series.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The term count is only changed while the block is idle.
   task automatic set_terms(input logic [TERMS_W-1:0] value);
      wait_for_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      terms_mirror  = value;
      terms_tried[value] = 1'b1;
   endtask

   // Receiver: picks the next ready level (long hold-off, random stall or
   // ready) and checks every result that is accepted on this edge.
   always @(posedge clock) begin
      series_result_type want;
      if (hold_requests != hold_served) begin
         hold_left   = HOLD_CYCLES;
         hold_served = hold_requests;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         stall_left = pick_gap();
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end

      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tuser) sat_seen++;
         if (pending_series.size() == 0) begin
            report_mismatch("result with nothing expected", rsp_tdata, '0);
         end else begin
            want = pending_series.pop_front();
            if (rsp_tdata !== want.value)
               report_mismatch("series_value", rsp_tdata, want.value);
            if (rsp_tuser !== want.sat)
               report_mismatch("saturated", 32'(rsp_tuser), 32'(want.sat));
         end
      end
   end

   // Watchdog: any accepted item on either channel restarts the count.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Fills the whole table, so no evaluation ever reads an unwritten entry,
   // then evaluates at zero, at plus and minus one and at the word extremes.
   // The table mixes small ramps with both coefficient extremes.
   task automatic test_table_and_points();
      logic [COEF_W-1:0] coef;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         if (k == 3)
            coef = WORD_MIN;
         else if (k == 7)
            coef = WORD_MAX;
         else if (k % 2 == 1)
            coef = -(k <<< 14);
         else
            coef = (k + 1) <<< 13;
         send_write(IDX_IN_W'(k), coef);
      end
      send_eval(X_ZERO);
      send_eval(X_PLUS_ONE);
      send_eval(X_MINUS_ONE);
      send_eval(WORD_MAX);
      send_eval(WORD_MIN);
   endtask

   // A count of zero acts as one term; a count above the table depth is
   // clamped to the full table.
   task automatic test_term_limits();
      set_terms(5'd0);
      send_eval(X_HALF);
      set_terms(5'd31);
      send_eval(X_NEG_HALF);
   endtask

   // A large top coefficient at the largest point makes the recurrence
   // state grow about fourfold each step until it clips.
   task automatic test_state_saturation();
      set_terms(5'd16);
      send_write(IDX_IN_W'(TABLE_DEPTH - 1), WORD_MAX);
      send_eval(WORD_MAX);
   endtask

   // Phases of random writes and evaluations, each under its own term
   // count. Every third phase runs with no idling on either side.
   task automatic test_random_series();
      logic [TERMS_W-1:0] terms;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: terms = 5'd1;
            1: terms = 5'd16;
            2: terms = 5'd0;
            3: terms = 5'd31;
            default: terms = TERMS_W'($urandom_range(2, 15));
         endcase
         set_terms(terms);
         idling_on = (phase % 3 != 2);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 9) < 3)
               send_write(IDX_IN_W'($urandom_range(0, 15)), random_coef());
            else
               send_eval(random_point());
         end
      end
      idling_on = 1'b1;
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering evaluations back to back, so the output register fills, the
   // next evaluation parks in its last step and the input stalls.
   task automatic test_backpressure();
      set_terms(5'd4);
      idling_on = 1'b0;
      hold_requests++;
      for (int n = 0; n < BURST_ITEMS; n++) begin
         send_eval(random_point());
      end
      idling_on = 1'b1;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      terms_tried[TERMS_RESET] = 1'b1;

      test_table_and_points();
      test_term_limits();
      test_state_saturation();
      test_random_series();
      test_backpressure();

      // Drain every owed result, then allow the block's latency to pass so
      // that a stray extra result would still be caught.
      wait_for_idle();
      foreach (pending_series[k]) begin
         report_mismatch("result never arrived", '0, pending_series[k].value);
      end

      $display("Sent %0d coefficient writes and %0d evaluations; %0d results, %0d saturated.",
               writes_sent, evals_sent, results_seen, sat_seen);
      $display("Ran under %0d term counts, including 0, 1, 16 and 31, with one long stall.",
               $countones(terms_tried));
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* chebyshev_series_evaluator_top.f */
src/cse_pkg.sv
src/chebyshev_series_evaluator_top.sv
src/cse_checker.sv
dv/tb_chebyshev_series_evaluator_top.sv
